// File: rtl/nrt_pkg.sv
// Name registry table: shared types and constants.
// Used by every module of the block; no dependencies.
`default_nettype none

package nrt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int ID_BITS_DEF     = 8;
  localparam int KEY_BITS        = 32;
  localparam int SENDER_BITS     = 8;
  localparam int FOUND_BITS      = 9;
  localparam int TYPE_BITS       = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [TYPE_BITS-1:0] REQ_LOOKUP   = 2'd0;
  localparam logic [TYPE_BITS-1:0] REQ_REGISTER = 2'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_REGISTER = 2'd1,
    OP_ACK      = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [KEY_BITS-1:0]   key;
    logic [SENDER_BITS-1:0] sender;
  } req_t;

endpackage

`default_nettype wire

// File: rtl/name_registry_table_unit.sv
// Name registry table, top level.
// Request channel: in_valid/in_ready with req_type, name_key, sender_id.
// Reply channel: out_valid/out_ready with reply_kind, found_id, table_full.
// A register request appends (name, id) to the next free entry and returns
// an empty acknowledgement; table_full is set when the table had no room and
// the request was dropped. A lookup returns the id of the earliest entry
// whose zero-terminated name matches, or -1. Other types are acknowledged.
// Requests are handled one at a time by the table engine; a two-entry queue
// in front of it keeps taking requests while it works.
// Register and other requests, and a lookup on an empty table, go straight to
// the reply; a lookup over filled entries first scans them in order, one entry
// a cycle through the store's single read port, and stops at the first match.
// Reset empties the table and the queue and drops any pending reply.
// While the receiver holds out_ready low the reply is held in the output
// register, the engine waits, and once the queue fills in_ready goes low.
`default_nettype none

module name_registry_table_unit #(
  parameter int TABLE_DEPTH = nrt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = nrt_pkg::ID_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [nrt_pkg::TYPE_BITS-1:0]       req_type,
  input  wire logic [nrt_pkg::KEY_BITS-1:0]        name_key,
  input  wire logic [nrt_pkg::SENDER_BITS-1:0]     sender_id,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     reply_kind,
  output logic signed [nrt_pkg::FOUND_BITS-1:0]    found_id,
  output logic                                     table_full
);

  logic          push_valid;
  logic          push_ready;
  nrt_pkg::req_t push_req;
  logic          pop_valid;
  logic          pop_ready;
  nrt_pkg::req_t pop_req;

  nrt_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .name_key   (name_key),
    .sender_id  (sender_id),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  nrt_queue #(
    .DEPTH (nrt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  nrt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_kind (reply_kind),
    .found_id   (found_id),
    .table_full (table_full)
  );

endmodule

`default_nettype wire

// File: rtl/nrt_front.sv
// Request front end: classifies the request type and normalizes the key.
// Depends on nrt_pkg.
`default_nettype none

module nrt_front (
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [nrt_pkg::TYPE_BITS-1:0]   req_type,
  input  wire logic [nrt_pkg::KEY_BITS-1:0]    name_key,
  input  wire logic [nrt_pkg::SENDER_BITS-1:0] sender_id,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output nrt_pkg::req_t                        push_req
);

  logic [nrt_pkg::KEY_BITS-1:0] key_norm;
  logic                         seen_zero;
  nrt_pkg::op_t                 op;

  // Clear every byte after the first zero byte.
  always_comb begin
    key_norm  = '0;
    seen_zero = 1'b0;
    for (int b = 0; b < nrt_pkg::KEY_BITS / 8; b++) begin
      if (name_key[8*b +: 8] == 8'd0) begin
        seen_zero = 1'b1;
      end
      if (!seen_zero) begin
        key_norm[8*b +: 8] = name_key[8*b +: 8];
      end
    end
  end

  always_comb begin
    case (req_type)
      nrt_pkg::REQ_LOOKUP:   op = nrt_pkg::OP_LOOKUP;
      nrt_pkg::REQ_REGISTER: op = nrt_pkg::OP_REGISTER;
      default:               op = nrt_pkg::OP_ACK;
    endcase
  end

  assign push_valid      = in_valid;
  assign in_ready        = push_ready;
  assign push_req.op     = op;
  assign push_req.key    = key_norm;
  assign push_req.sender = sender_id;

endmodule

`default_nettype wire

// File: rtl/nrt_queue.sv
// Short request queue between the front end and the table engine.
// Depends on nrt_pkg.
`default_nettype none

module nrt_queue #(
  parameter int DEPTH = nrt_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire nrt_pkg::req_t push_req,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output nrt_pkg::req_t      pop_req
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  nrt_pkg::req_t   slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CntW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_req    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nrt_back.sv
// Table engine: entry store, append on register, sequential scan on lookup,
// and the output register. Depends on nrt_pkg.
`default_nettype none

module nrt_back #(
  parameter int TABLE_DEPTH = nrt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = nrt_pkg::ID_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pop_valid,
  output logic                                     pop_ready,
  input  wire nrt_pkg::req_t                       pop_req,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     reply_kind,
  output logic signed [nrt_pkg::FOUND_BITS-1:0]    found_id,
  output logic                                     table_full
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  // A stored id never carries more bits than the sender field.
  localparam int IdW  = (ID_BITS < nrt_pkg::SENDER_BITS) ? ID_BITS : nrt_pkg::SENDER_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  logic [nrt_pkg::KEY_BITS-1:0] name_mem [TABLE_DEPTH];
  logic [IdW-1:0]               id_mem   [TABLE_DEPTH];

  state_t                          state;
  logic [CntW-1:0]                 entry_count;
  logic [CntW-1:0]                 issue_idx;
  logic                            cmp_valid;
  logic                            cmp_last;
  logic [nrt_pkg::KEY_BITS-1:0]    key_r;
  logic [nrt_pkg::KEY_BITS-1:0]    rd_name;
  logic [IdW-1:0]                  rd_id;
  logic                            res_kind;
  logic [nrt_pkg::FOUND_BITS-1:0]  res_found;
  logic                            res_full;

  logic take;
  logic is_full;
  logic wr_en;
  logic hit;
  logic miss;
  logic out_free;

  assign pop_ready = (state == ST_IDLE);
  assign take      = pop_valid && pop_ready;
  assign is_full   = (entry_count == CntW'(TABLE_DEPTH));
  assign wr_en     = take && (pop_req.op == nrt_pkg::OP_REGISTER) && !is_full;
  assign hit       = cmp_valid && (rd_name == key_r);
  assign miss      = cmp_valid && cmp_last && !hit;
  assign out_free  = !out_valid || out_ready;

  // Entry store: append at entry_count, read one entry a cycle during a scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[entry_count[IdxW-1:0]] <= pop_req.key;
      id_mem[entry_count[IdxW-1:0]]   <= pop_req.sender[IdW-1:0];
    end
    rd_name <= name_mem[issue_idx[IdxW-1:0]];
    rd_id   <= id_mem[issue_idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= out_valid && !out_ready;
      case (state)
        ST_IDLE: begin
          if (take) begin
            cmp_valid <= 1'b0;
            if (pop_req.op == nrt_pkg::OP_LOOKUP && entry_count != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_EMIT;
            end
            if (wr_en) begin
              entry_count <= entry_count + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          cmp_valid <= (issue_idx < entry_count);
          if (hit || miss) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          key_r     <= pop_req.key;
          issue_idx <= '0;
          cmp_last  <= 1'b0;
          res_kind  <= (pop_req.op != nrt_pkg::OP_LOOKUP);
          res_found <= (pop_req.op == nrt_pkg::OP_LOOKUP) ? '1 : '0;
          res_full  <= (pop_req.op == nrt_pkg::OP_REGISTER) && is_full;
        end
      end
      ST_SCAN: begin
        // Miss leaves the all-ones answer loaded at the start of the lookup.
        if (hit) begin
          res_found <= {{(nrt_pkg::FOUND_BITS - IdW){1'b0}}, rd_id};
        end
        issue_idx <= issue_idx + 1'b1;
        cmp_last  <= ((issue_idx + 1'b1) == entry_count);
      end
      ST_EMIT: begin
        if (out_free) begin
          reply_kind <= res_kind;
          found_id   <= res_found;
          table_full <= res_full;
        end
      end
      default: begin
        issue_idx <= issue_idx;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for name_registry_table_unit: directed and random register/lookup traffic.
// Depends on nrt_pkg and the block's RTL; checks every reply against an in-bench table model.

module tb;

  localparam logic [nrt_pkg::TYPE_BITS-1:0] REQ_SPARE = 2'd3;
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_ACK    = 1'b1;
  localparam logic signed [nrt_pkg::FOUND_BITS-1:0] NO_MATCH = '1;
  localparam logic [7:0] CH_A = "a";
  localparam logic [7:0] CH_W = "w";
  localparam logic [7:0] CH_R = "r";
  localparam int DEPTH          = nrt_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_AFTER     = 400;
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = DEPTH + 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    logic [nrt_pkg::TYPE_BITS-1:0]   kind;
    logic [nrt_pkg::KEY_BITS-1:0]    key;
    logic [nrt_pkg::SENDER_BITS-1:0] sender;
  } name_req_t;

  typedef struct {
    logic                                   kind;
    logic signed [nrt_pkg::FOUND_BITS-1:0]  found;
    logic                                   full;
  } registry_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [nrt_pkg::TYPE_BITS-1:0] req_type = '0;
  logic [nrt_pkg::KEY_BITS-1:0] name_key = '0;
  logic [nrt_pkg::SENDER_BITS-1:0] sender_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic reply_kind;
  logic signed [nrt_pkg::FOUND_BITS-1:0] found_id;
  logic table_full;

  name_registry_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .name_key  (name_key),
    .sender_id (sender_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reply_kind(reply_kind),
    .found_id  (found_id),
    .table_full(table_full)
  );

  // Table model state
  logic [nrt_pkg::KEY_BITS-1:0]      known_names [DEPTH];
  logic [nrt_pkg::ID_BITS_DEF-1:0]   known_ids   [DEPTH];
  int                                names_filled = 0;

  name_req_t        requests_to_send[$];
  registry_reply_t  replies_due[$];
  logic [nrt_pkg::KEY_BITS-1:0] sent_names[$];
  int fail_count = 0;
  int replies_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Clear every byte after the first zero byte.
  function automatic logic [nrt_pkg::KEY_BITS-1:0] trim_name(
      logic [nrt_pkg::KEY_BITS-1:0] raw);
    logic [nrt_pkg::KEY_BITS-1:0] kept;
    logic ended;
    int b;
    kept = '0;
    ended = 1'b0;
    for (b = 0; b < 4; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

  function automatic registry_reply_t predict_reply(logic [nrt_pkg::TYPE_BITS-1:0] kind,
                                                    logic [nrt_pkg::KEY_BITS-1:0] key,
                                                    logic [nrt_pkg::SENDER_BITS-1:0] sender);
    registry_reply_t r;
    logic [nrt_pkg::KEY_BITS-1:0] name;
    logic hit;
    int i;
    name = trim_name(key);
    r.kind = KIND_ACK;
    r.found = '0;
    r.full = 1'b0;
    hit = 1'b0;
    if (kind == nrt_pkg::OP_LOOKUP) begin
      r.kind = KIND_ANSWER;
      r.found = NO_MATCH;
      for (i = 0; i < names_filled; i++) begin
        if (!hit && known_names[i] == name) begin
          r.found = nrt_pkg::FOUND_BITS'(known_ids[i]);
          hit = 1'b1;
        end
      end
    end else if (kind == nrt_pkg::OP_REGISTER) begin
      if (names_filled < DEPTH) begin
        known_names[names_filled] = name;
        known_ids[names_filled] = sender[nrt_pkg::ID_BITS_DEF-1:0];
        names_filled++;
      end else begin
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic push_req(logic [nrt_pkg::TYPE_BITS-1:0] kind,
                          logic [nrt_pkg::KEY_BITS-1:0] key,
                          logic [nrt_pkg::SENDER_BITS-1:0] sender);
    name_req_t req;
    req.kind = kind;
    req.key = key;
    req.sender = sender;
    requests_to_send.push_back(req);
    if (kind == nrt_pkg::OP_REGISTER && sent_names.size() < DEPTH)
      sent_names.push_back(trim_name(key));
  endtask

  function automatic logic [nrt_pkg::KEY_BITS-1:0] random_name();
    logic [nrt_pkg::KEY_BITS-1:0] k;
    int len;
    int b;
    k = $urandom;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (b = 0; b < len; b++) begin
      if ($urandom_range(0, 3) == 0) k[8*b +: 8] = 8'($urandom_range(1, 255));
      else k[8*b +: 8] = CH_A + 8'($urandom_range(0, 2));
    end
    if (len < 4) begin
      k[8*len +: 8] = 8'h00;
      if ($urandom_range(0, 1) == 0) begin
        for (b = len + 1; b < 4; b++) k[8*b +: 8] = 8'h00;
      end
    end
    return k;
  endfunction

  // Fill the bytes past the terminator with junk.
  function automatic logic [nrt_pkg::KEY_BITS-1:0] dirty_name(
      logic [nrt_pkg::KEY_BITS-1:0] k);
    logic [nrt_pkg::KEY_BITS-1:0] junk;
    logic [nrt_pkg::KEY_BITS-1:0] mixed;
    logic ended;
    int b;
    junk = $urandom;
    mixed = k;
    ended = 1'b0;
    for (b = 0; b < 4; b++) begin
      if (ended) mixed[8*b +: 8] = junk[8*b +: 8];
      if (k[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return mixed;
  endfunction

  function automatic logic [nrt_pkg::KEY_BITS-1:0] known_or_fresh(int hit_pct);
    logic [nrt_pkg::KEY_BITS-1:0] k;
    if (sent_names.size() > 0 && $urandom_range(0, 99) < hit_pct) begin
      k = sent_names[$urandom_range(0, sent_names.size() - 1)];
      if ($urandom_range(0, 1) == 0) k = dirty_name(k);
    end else begin
      k = random_name();
    end
    return k;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  task automatic flag_mismatch(string msg);
    if (fail_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_reply();
    registry_reply_t want;
    if (replies_due.size() == 0) begin
      flag_mismatch($sformatf("reply %0d arrived with nothing outstanding", replies_seen));
    end else begin
      want = replies_due.pop_front();
      if (reply_kind !== want.kind)
        flag_mismatch($sformatf("reply %0d: reply_kind %b, want %b",
                                replies_seen, reply_kind, want.kind));
      if (found_id !== want.found)
        flag_mismatch($sformatf("reply %0d: found_id %0d, want %0d",
                                replies_seen, found_id, want.found));
      if (table_full !== want.full)
        flag_mismatch($sformatf("reply %0d: table_full %b, want %b",
                                replies_seen, table_full, want.full));
    end
  endtask

  // Request driver
  int tx_gap = 0;
  int tx_calm = 0;
  always @(posedge clk) begin : drive_requests
    name_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready)
        replies_due.push_back(predict_reply(req_type, name_key, sender_id));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0 || requests_to_send.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = requests_to_send.pop_front();
          req_type  <= nxt.kind;
          name_key  <= nxt.key;
          sender_id <= nxt.sender;
          in_valid  <= 1'b1;
          if (tx_calm > 0) tx_calm--;
          else if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 60);
          tx_gap = (tx_calm > 0) ? 0 : pick_pause();
        end
      end
    end
  end

  // Reply monitor and receiver stalls
  int rx_wait = 0;
  int rx_calm = 0;
  int hold_left = 0;
  logic held_once = 1'b0;
  always @(posedge clk) begin : watch_replies
    int p;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply();
        replies_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && replies_seen >= HOLD_AFTER) begin
        // hold off long enough for the queue to fill and stall the input
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 60);
        p = (rx_calm > 0) ? 0 : pick_pause();
        rx_wait = (p > 0) ? p - 1 : 0;
        out_ready <= (p == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no request or reply moves for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int r;
    // Lookup on an empty table, both ack types
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, 8'h00, "b", "a"}, 8'h00);
    push_req(nrt_pkg::OP_ACK,      32'hFFFF_FFFF, 8'hFF);
    push_req(REQ_SPARE,            32'h0000_0000, 8'h00);
    // Empty name with junk, duplicates, all-ones key, short names
    push_req(nrt_pkg::OP_REGISTER, 32'hA5C3_7E00, 8'hFF);
    push_req(nrt_pkg::OP_REGISTER, {8'h00, 8'h00, "b", "a"}, 8'h01);
    push_req(nrt_pkg::OP_REGISTER, {8'h5A, 8'h00, "b", "a"}, 8'h02);
    push_req(nrt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 8'h80);
    push_req(nrt_pkg::OP_REGISTER, {8'h3C, 8'h99, 8'h00, CH_W}, 8'h7F);
    push_req(nrt_pkg::OP_REGISTER, {8'h00, CH_R, CH_R, CH_R}, 8'h00);
    push_req(nrt_pkg::OP_REGISTER, {8'h00, 8'h00, CH_R, CH_W}, 8'hAA);
    push_req(nrt_pkg::OP_LOOKUP,   32'h1234_5600, 8'h55);
    push_req(nrt_pkg::OP_LOOKUP,   32'h0000_0000, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, 8'h00, "b", "a"}, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'hFF, 8'h00, "b", "a"}, 8'hFF);
    push_req(nrt_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   32'h7FFF_FFFF, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, 8'h00, 8'h00, CH_W}, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, CH_R, CH_R, CH_R}, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, 8'h00, CH_R, CH_R}, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'h00, "c", "b", "a"}, 8'h00);
    push_req(nrt_pkg::OP_LOOKUP,   {8'hE1, 8'h00, CH_R, CH_W}, 8'h00);
    push_req(REQ_SPARE,            32'hFFFF_FFFF, 8'hFF);

    // Random mix; registers fill the table partway through, then get dropped
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      push_req(nrt_pkg::OP_LOOKUP, known_or_fresh(70), 8'($urandom));
      else if (r < 85) push_req(nrt_pkg::OP_REGISTER, known_or_fresh(30), 8'($urandom));
      else if (r < 95) push_req(nrt_pkg::OP_ACK, $urandom, 8'($urandom));
      else             push_req(REQ_SPARE, $urandom, 8'($urandom));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (requests_to_send.size() != 0 || in_valid || replies_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/nrt_pkg.sv
rtl/nrt_front.sv
rtl/nrt_queue.sv
rtl/nrt_back.sv
rtl/name_registry_table_unit.sv
tb/tb.sv
